FILE: rtl/keyed_log_throttle_table_macros.svh
// Assertion macros shared by the checker files of the throttle table.
// No dependencies; the checker supplies clock and reset by name.
`ifndef KEYED_LOG_THROTTLE_TABLE_MACROS_SVH
`define KEYED_LOG_THROTTLE_TABLE_MACROS_SVH

// Property that must hold at every clock edge out of reset
`define KLT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Implication from one cycle into the next
`define KLT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/klt_pkg.sv
// Shared types and constants for the keyed log throttle table.
// No dependencies.
`default_nettype none

package klt_pkg;

   localparam int SLOTS_DEFAULT = 16;
   localparam int SLOT_ID_W     = 4;

   // Request word
   typedef struct packed {
      logic        key_present;
      logic [31:0] key_hash;
      logic [63:0] key_tag_low;
      logic [23:0] key_tag_high;
      logic [31:0] now_ms;
      logic [31:0] interval_ms;
   } req_type;

   // Result word
   typedef struct packed {
      logic                 pass;
      logic [SLOT_ID_W-1:0] slot_used;
      logic                 matched;
      logic                 replaced;
   } rsp_type;

   // One table slot
   typedef struct packed {
      logic [31:0] hash;
      logic [31:0] stamp_ms;
      logic [63:0] tag_low;
      logic [23:0] tag_high;
   } entry_type;

endpackage

`default_nettype wire

FILE: rtl/keyed_log_throttle_table.sv
// Top level of the keyed log throttle table: request sequencer and slot scan.
// Depends on klt_pkg and klt_store.
`default_nettype none

// Per-key rate limiter. A request is taken when start is high and busy is
// low; its result word appears on rsp_data with rsp_strobe high for a
// single cycle and cannot be held off. When disabled, or when the key is
// absent or the interval is zero, the result follows in the cycle after the
// request and a new request may come every cycle. Otherwise the block scans
// the table one slot per cycle through a single registered memory read port
// and one shared subtract/compare unit, stopping early when the key is found;
// busy stays high and no new request is taken until the result is registered.
// The table is empty after reset at once; there is no clearing pass.
// csr_ready is always high.
module keyed_log_throttle_table #(
   parameter int SLOTS = klt_pkg::SLOTS_DEFAULT
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   output logic               busy,
   input  klt_pkg::req_type   req_data,
   output logic               rsp_strobe,
   output klt_pkg::rsp_type   rsp_data,
   input  wire                csr_valid,
   output logic               csr_ready,
   input  wire                csr_data
);

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);
   localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(SLOTS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE
   } state_type;

   state_type          state_ff, state_in;
   logic               enable_ff, enable_in;
   klt_pkg::req_type   req_ff, req_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic               chk_ff, chk_in;
   logic [IDX_W-1:0]   chk_idx_ff, chk_idx_in;
   logic               have_empty_ff, have_empty_in;
   logic [IDX_W-1:0]   empty_idx_ff, empty_idx_in;
   logic               have_old_ff, have_old_in;
   logic [IDX_W-1:0]   old_idx_ff, old_idx_in;
   logic [31:0]        old_age_ff, old_age_in;
   logic               matched_ff, matched_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   klt_pkg::rsp_type   rsp_ff, rsp_in;

   logic [IDX_W-1:0]   rd_addr;
   klt_pkg::entry_type rd_entry;
   logic               rd_occ;
   logic               wr_en;
   klt_pkg::entry_type wr_entry;

   logic [31:0]        scan_age;
   logic               hit;
   logic               use_old;
   logic [IDX_W-1:0]   sel_idx;
   logic               drop;

   // Slot store
   klt_store #(
      .SLOTS (SLOTS)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_addr  (rd_addr),
      .rd_entry (rd_entry),
      .rd_occ   (rd_occ),
      .wr_en    (wr_en),
      .wr_addr  (sel_idx),
      .wr_entry (wr_entry)
   );

   // Shared unit: wrapping age and key compare of the slot just read
   assign scan_age = req_ff.now_ms - rd_entry.stamp_ms;
   assign hit      = rd_occ && (rd_entry.hash == req_ff.key_hash) &&
                     (rd_entry.tag_low == req_ff.key_tag_low) &&
                     (rd_entry.tag_high == req_ff.key_tag_high);

   // Slot choice: match or oldest use the old_* registers, else first empty
   assign use_old = matched_ff || (!have_empty_ff && have_old_ff);
   always_comb begin
      if (use_old) begin
         sel_idx = old_idx_ff;
      end else if (have_empty_ff) begin
         sel_idx = empty_idx_ff;
      end else begin
         sel_idx = '0;
      end
   end
   assign drop = use_old && (old_age_ff < req_ff.interval_ms);

   // New slot contents
   always_comb begin
      wr_entry.hash     = req_ff.key_hash;
      wr_entry.stamp_ms = req_ff.now_ms;
      wr_entry.tag_low  = req_ff.key_tag_low;
      wr_entry.tag_high = req_ff.key_tag_high;
   end

   // Sequencer next state
   always_comb begin
      state_in      = state_ff;
      enable_in     = enable_ff;
      req_in        = req_ff;
      idx_in        = idx_ff;
      chk_in        = chk_ff;
      chk_idx_in    = chk_idx_ff;
      have_empty_in = have_empty_ff;
      empty_idx_in  = empty_idx_ff;
      have_old_in   = have_old_ff;
      old_idx_in    = old_idx_ff;
      old_age_in    = old_age_ff;
      matched_in    = matched_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      rd_addr       = idx_ff[IDX_W-1:0];
      wr_en         = 1'b0;

      // config word
      if (csr_valid) begin
         enable_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in = req_data;
               if (req_data.key_hash == '0) begin
                  req_in.key_hash = 32'd1;
               end
               rsp_in.pass      = 1'b0;
               rsp_in.slot_used = '0;
               rsp_in.matched   = 1'b0;
               rsp_in.replaced  = 1'b0;
               if (!enable_ff) begin
                  rsp_strobe_in = 1'b1;
               end else if (!req_data.key_present || (req_data.interval_ms == '0)) begin
                  rsp_strobe_in = 1'b1;
                  rsp_in.pass   = 1'b1;
               end else begin
                  state_in      = ST_SCAN;
                  idx_in        = '0;
                  chk_in        = 1'b0;
                  have_empty_in = 1'b0;
                  have_old_in   = 1'b0;
                  matched_in    = 1'b0;
               end
            end
         end
         ST_SCAN: begin
            // issue the next read
            chk_in = 1'b0;
            if (idx_ff != CNT_END) begin
               chk_in     = 1'b1;
               chk_idx_in = idx_ff[IDX_W-1:0];
               idx_in     = idx_ff + 1'b1;
            end
            // check the slot read last cycle
            if (chk_ff) begin
               if (hit) begin
                  matched_in = 1'b1;
                  old_idx_in = chk_idx_ff;
                  old_age_in = scan_age;
                  state_in   = ST_DECIDE;
               end else begin
                  if (!rd_occ) begin
                     if (!have_empty_ff) begin
                        have_empty_in = 1'b1;
                        empty_idx_in  = chk_idx_ff;
                     end
                  end else if (!have_old_ff || (scan_age > old_age_ff)) begin
                     have_old_in = 1'b1;
                     old_idx_in  = chk_idx_ff;
                     old_age_in  = scan_age;
                  end
                  if (chk_idx_ff == LAST_IDX) begin
                     state_in = ST_DECIDE;
                  end
               end
            end
         end
         ST_DECIDE: begin
            wr_en            = !drop;
            rsp_strobe_in    = 1'b1;
            rsp_in.pass      = !drop;
            rsp_in.slot_used = klt_pkg::SLOT_ID_W'(sel_idx);
            rsp_in.matched   = matched_ff;
            rsp_in.replaced  = !drop && use_old && !matched_ff;
            state_in         = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      idx_ff        <= idx_in;
      chk_idx_ff    <= chk_idx_in;
      have_empty_ff <= have_empty_in;
      empty_idx_ff  <= empty_idx_in;
      have_old_ff   <= have_old_in;
      old_idx_ff    <= old_idx_in;
      old_age_ff    <= old_age_in;
      matched_ff    <= matched_in;
      rsp_ff        <= rsp_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         enable_ff     <= 1'b1;
         chk_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         enable_ff     <= enable_in;
         chk_ff        <= chk_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;
   assign csr_ready  = 1'b1;

endmodule

`default_nettype wire

FILE: rtl/klt_store.sv
// Slot store: entry memory with registered read, plus per-slot occupied bits.
// Depends on klt_pkg.
`default_nettype none

module klt_store #(
   parameter int SLOTS = klt_pkg::SLOTS_DEFAULT,
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire  [IDX_W-1:0]            rd_addr,
   output klt_pkg::entry_type          rd_entry,
   output logic                        rd_occ,
   input  wire                         wr_en,
   input  wire  [IDX_W-1:0]            wr_addr,
   input  klt_pkg::entry_type          wr_entry
);

   klt_pkg::entry_type mem [SLOTS];
   logic [SLOTS-1:0]   vld_ff;
   klt_pkg::entry_type rd_entry_ff;
   logic               rd_occ_ff;

   // Entry memory: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
      rd_entry_ff <= mem[rd_addr];
   end

   // Occupied bits, cleared at reset; an unoccupied slot reads as empty
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_occ_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         rd_occ_ff <= vld_ff[rd_addr];
      end
   end

   assign rd_entry = rd_entry_ff;
   assign rd_occ   = rd_occ_ff;

endmodule

`default_nettype wire

FILE: rtl/klt_checker.sv
// Port-level checks for the keyed log throttle table, bound to the top level.
// Depends on klt_pkg and keyed_log_throttle_table_macros.svh.
`default_nettype none

`include "keyed_log_throttle_table_macros.svh"

module klt_checker (
   input wire              clock,
   input wire              reset,
   input wire              start,
   input wire              busy,
   input wire              rsp_strobe,
   input klt_pkg::rsp_type rsp_data
);

   // a taken request either answers at once or starts a scan
   `KLT_ASSERT_NEXT(a_accept_progress, start && !busy, busy || rsp_strobe, "request lost")

   // the end of a scan always delivers a result word
   `KLT_ASSERT(a_scan_ends_in_result, !($fell(busy) && !$past(reset)) || rsp_strobe, "scan without result")

   // no result word while a scan is running
   `KLT_ASSERT(a_quiet_while_busy, !(busy && rsp_strobe), "result during scan")

   // a replacement only happens on a pass of a new key
   `KLT_ASSERT(a_replace_consistent, !(rsp_strobe && rsp_data.replaced && (rsp_data.matched || !rsp_data.pass)), "bad replace flag")

endmodule

bind keyed_log_throttle_table klt_checker u_klt_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

`default_nettype wire

FILE: dv/tb_keyed_log_throttle_table.sv
// Self-checking testbench for keyed_log_throttle_table: directed tests, then random traffic.
// Depends on klt_pkg and the keyed_log_throttle_table RTL; holds its own table predictor.
`default_nettype none

module tb_keyed_log_throttle_table;

   localparam int TABLE_SLOTS = klt_pkg::SLOTS_DEFAULT;
   localparam int CYCLE_LIMIT = 600000;
   localparam int POOL_MAX    = 24;
   localparam int SETTLE_WAIT = TABLE_SLOTS + 8;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   klt_pkg::req_type req_data;
   logic             rsp_strobe;
   klt_pkg::rsp_type rsp_data;
   logic             csr_valid;
   logic             csr_ready;
   logic             csr_data;

   keyed_log_throttle_table uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // Clock: period 2
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Predictor state: table copy and the enable register
   logic [31:0] tbl_hash   [TABLE_SLOTS];
   logic [31:0] tbl_stamp  [TABLE_SLOTS];
   logic [63:0] tbl_tag_lo [TABLE_SLOTS];
   logic [23:0] tbl_tag_hi [TABLE_SLOTS];
   logic        high_freq_on;

   klt_pkg::rsp_type pending_verdicts[$];
   int          error_count;
   int          cycle_count;
   int          sender_idle_pct;

   // Random traffic: key pool and running time base
   logic [31:0] pool_hash   [POOL_MAX];
   logic [63:0] pool_tag_lo [POOL_MAX];
   logic [23:0] pool_tag_hi [POOL_MAX];
   int          pool_used;
   logic [31:0] sim_now;

   // Verdict for one request; updates the table copy as the block would
   function automatic klt_pkg::rsp_type predict_throttle(input klt_pkg::req_type w);
      klt_pkg::rsp_type r;
      logic [31:0] h;
      logic [31:0] age;
      logic [31:0] best_age;
      int          pick;
      int          oldest;
      bit          have_pick;
      bit          hit;
      bit          have_oldest;
      bit          occ;
      r = '0;
      if (!high_freq_on)
         return r;
      h = (w.key_hash == 32'd0) ? 32'd1 : w.key_hash;
      if (!w.key_present || w.interval_ms == 32'd0) begin
         r.pass = 1'b1;
         return r;
      end
      pick = 0;
      oldest = 0;
      best_age = '0;
      have_pick = 1'b0;
      hit = 1'b0;
      have_oldest = 1'b0;
      // scan: first exact match wins, else remember first empty and oldest
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         if (tbl_hash[i] == h && tbl_tag_lo[i] == w.key_tag_low &&
             tbl_tag_hi[i] == w.key_tag_high) begin
            pick = i;
            have_pick = 1'b1;
            hit = 1'b1;
            break;
         end
         if (tbl_hash[i] == 32'd0) begin
            if (!have_pick) begin
               pick = i;
               have_pick = 1'b1;
            end
         end else begin
            age = w.now_ms - tbl_stamp[i];
            if (!have_oldest || age > best_age) begin
               oldest = i;
               best_age = age;
               have_oldest = 1'b1;
            end
         end
      end
      if (!have_pick)
         pick = have_oldest ? oldest : 0;
      occ = (tbl_hash[pick] != 32'd0);
      r.slot_used = pick[klt_pkg::SLOT_ID_W-1:0];
      r.matched = hit;
      // too soon since the last pass for this slot: drop
      if (occ && (w.now_ms - tbl_stamp[pick]) < w.interval_ms)
         return r;
      tbl_hash[pick] = h;
      tbl_stamp[pick] = w.now_ms;
      tbl_tag_lo[pick] = w.key_tag_low;
      tbl_tag_hi[pick] = w.key_tag_high;
      r.pass = 1'b1;
      r.replaced = occ && !hit;
      return r;
   endfunction

   function automatic klt_pkg::req_type mk_req(input logic present, input logic [31:0] h,
                                               input logic [63:0] tlo, input logic [23:0] thi,
                                               input logic [31:0] now, input logic [31:0] ivl);
      klt_pkg::req_type w;
      w.key_present = present;
      w.key_hash = h;
      w.key_tag_low = tlo;
      w.key_tag_high = thi;
      w.now_ms = now;
      w.interval_ms = ivl;
      return w;
   endfunction

   // Send one request word; start stays high unless a gap follows
   task automatic send_request(input klt_pkg::req_type w);
      start <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      pending_verdicts.push_back(predict_throttle(w));
      if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         do
            @(posedge clock);
         while ($urandom_range(99) < sender_idle_pct);
      end
   endtask

   // Stop sending and wait until every verdict is back and the block is quiet
   task automatic drain_requests();
      start <= 1'b0;
      @(posedge clock);
      while (pending_verdicts.size() != 0)
         @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   // Write the enable register; block must be idle
   task automatic set_high_freq(input logic v);
      drain_requests();
      csr_valid <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      high_freq_on = v;
      csr_valid <= 1'b0;
   endtask

   // Random keys with a few near twins: hash 0 vs 1, one flipped tag bit
   task automatic fill_key_pool(input int n);
      int b;
      pool_used = n;
      for (int i = 0; i < n; i++) begin
         pool_hash[i] = $urandom;
         pool_tag_lo[i] = {$urandom, $urandom};
         pool_tag_hi[i] = 24'($urandom);
      end
      if (n >= 4) begin
         pool_hash[1] = 32'd0;
         pool_hash[2] = 32'd1;
         pool_tag_lo[2] = pool_tag_lo[1];
         pool_tag_hi[2] = pool_tag_hi[1];
         b = $urandom_range(87);
         {pool_tag_hi[3], pool_tag_lo[3]} = {pool_tag_hi[0], pool_tag_lo[0]} ^ (88'd1 << b);
         pool_hash[3] = pool_hash[0];
      end
   endtask

   function automatic klt_pkg::req_type make_traffic_item();
      klt_pkg::req_type w;
      int      k;
      int      pick;
      pick = $urandom_range(99);
      w = mk_req(1'($urandom), $urandom, {$urandom, $urandom}, 24'($urandom),
                 $urandom, $urandom);
      if (pick < 82) begin
         // well-formed request for a pooled key, time moving forward
         k = $urandom_range(pool_used - 1);
         sim_now = sim_now + $urandom_range(0, 200);
         w.key_present = 1'b1;
         w.key_hash = pool_hash[k];
         w.key_tag_low = pool_tag_lo[k];
         w.key_tag_high = pool_tag_hi[k];
         w.now_ms = sim_now;
         case ($urandom_range(19))
            0:       w.interval_ms = 32'd0;
            1:       w.interval_ms = $urandom;
            default: w.interval_ms = $urandom_range(1, 800);
         endcase
      end else if (pick < 92) begin
         w.key_present = 1'b0;
      end else if (pick < 96) begin
         // pooled key at a wild time: time going backwards or far ahead
         k = $urandom_range(pool_used - 1);
         w.key_present = 1'b1;
         w.key_hash = pool_hash[k];
         w.key_tag_low = pool_tag_lo[k];
         w.key_tag_high = pool_tag_hi[k];
      end else begin
         w.key_present = 1'b1;
      end
      return w;
   endfunction

   // Absent key and zero interval bypass the table
   task automatic test_bypass();
      send_request(mk_req(1'b0, '1, '1, '1, '1, '1));
      send_request(mk_req(1'b0, '0, '0, '0, '0, '0));
      send_request(mk_req(1'b1, '1, '1, '1, '1, '0));
   endtask

   // Match, drop of a known key, hash-zero aliasing and exact tag compare
   task automatic test_match_and_drop();
      send_request(mk_req(1'b1, 32'd0, 64'h0123_4567_89ab_cdef, 24'h5a5a5a, 32'd100, 32'd50));
      send_request(mk_req(1'b1, 32'd1, 64'h0123_4567_89ab_cdef, 24'h5a5a5a, 32'd120, 32'd50));
      send_request(mk_req(1'b1, 32'd1, 64'h0123_4567_89ab_cdef, 24'hda5a5a, 32'd130, 32'd50));
      send_request(mk_req(1'b1, 32'd1, 64'h0123_4567_89ab_cdee, 24'h5a5a5a, 32'd140, 32'd50));
      send_request(mk_req(1'b1, 32'd1, 64'h0123_4567_89ab_cdef, 24'h5a5a5a, 32'd150, 32'd50));
   endtask

   // Fill the table, then force eviction: suppressed, then replacing
   task automatic test_fill_and_evict();
      for (int i = 0; i < TABLE_SLOTS - 3; i++)
         send_request(mk_req(1'b1, 32'hFFFF_FFF3 + i, ~64'(i), '1, 32'd200 + i, 32'd5));
      send_request(mk_req(1'b1, 32'h1234_5678, 64'd7, 24'd7, 32'd300, 32'd1000));
      send_request(mk_req(1'b1, 32'h1234_5678, 64'd7, 24'd7, 32'd300, 32'd100));
      // known key, maximum interval: dropped
      send_request(mk_req(1'b1, 32'd1, 64'h0123_4567_89ab_cdef, 24'h5a5a5a, 32'd160, '1));
      // wrapped age passes for a stored key
      send_request(mk_req(1'b1, 32'd1, 64'h0123_4567_89ab_cdee, 24'h5a5a5a, 32'd5, 32'd10));
   endtask

   // Disabled: every request dropped, table untouched
   task automatic test_disabled();
      set_high_freq(1'b0);
      send_request(mk_req(1'b0, '0, '0, '0, '0, '0));
      send_request(mk_req(1'b1, '1, '1, '1, 32'd400, 32'd1));
      send_request(mk_req(1'b1, 32'd1, 64'h0123_4567_89ab_cdef, 24'h5a5a5a, 32'd900, 32'd1));
      set_high_freq(1'b1);
   endtask

   // Random traffic in batches, with enable changes between batches
   task automatic test_random_traffic(input int idle_pct, input int batches);
      int n;
      sender_idle_pct = idle_pct;
      for (int b = 0; b < batches; b++) begin
         if (b != 0 && $urandom_range(3) == 0)
            set_high_freq(1'b0);
         else if (!high_freq_on)
            set_high_freq(1'b1);
         fill_key_pool($urandom_range(4, POOL_MAX));
         sim_now = ($urandom_range(3) == 0) ? 32'hFFFF_F000 + $urandom_range(4095) : $urandom;
         n = high_freq_on ? 125 : 20;
         for (int i = 0; i < n; i++)
            send_request(make_traffic_item());
      end
      sender_idle_pct = 0;
   endtask

   // Result checker: each strobed word against the oldest verdict
   always @(posedge clock) begin
      klt_pkg::rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_verdicts.size() == 0) begin
            $error("unexpected result word %p", rsp_data);
            error_count++;
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_data.pass !== want.pass) begin
               $error("pass: expected %0d, got %0d", want.pass, rsp_data.pass);
               error_count++;
            end
            if (rsp_data.slot_used !== want.slot_used) begin
               $error("slot_used: expected %0d, got %0d", want.slot_used, rsp_data.slot_used);
               error_count++;
            end
            if (rsp_data.matched !== want.matched) begin
               $error("matched: expected %0d, got %0d", want.matched, rsp_data.matched);
               error_count++;
            end
            if (rsp_data.replaced !== want.replaced) begin
               $error("replaced: expected %0d, got %0d", want.replaced, rsp_data.replaced);
               error_count++;
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = 1'b0;
      error_count = 0;
      cycle_count = 0;
      sender_idle_pct = 0;
      pool_used = 1;
      sim_now = '0;
      high_freq_on = 1'b1;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         tbl_hash[i] = '0;
         tbl_stamp[i] = '0;
         tbl_tag_lo[i] = '0;
         tbl_tag_hi[i] = '0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_bypass();
      test_match_and_drop();
      test_fill_and_evict();
      test_disabled();
      test_random_traffic(17, 3);
      test_random_traffic(75, 3);
      test_random_traffic(0, 3);

      drain_requests();
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+rtl
rtl/klt_pkg.sv
rtl/klt_store.sv
rtl/keyed_log_throttle_table.sv
rtl/klt_checker.sv
dv/tb_keyed_log_throttle_table.sv
